// ----- sv/mmef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mmef_pkg;

    localparam int ValueW       = 28;
    localparam int QueueDepthDf = 2;

    localparam logic       CMD_HEADER  = 1'b0;
    localparam logic       CMD_PAYLOAD = 1'b1;
    localparam logic [7:0] META_BYTE   = 8'hff;
    localparam logic [7:0] VLQ_CONT    = 8'h80;

    typedef struct packed {
        logic              command;
        logic [ValueW-1:0] delta_ticks;
        logic [7:0]        meta_type;
        logic [ValueW-1:0] payload_length;
        logic [7:0]        data_byte;
    } mmef_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       event_end;
    } mmef_out_t;

    // queue entry: classified transaction plus end flag for payload bytes
    typedef struct packed {
        mmef_in_t item;
        logic     last;
    } mmef_qent_t;

    typedef struct packed {
        logic empty;
        logic full;
    } mmef_qstat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DELTA,
        BK_META,
        BK_TYPE,
        BK_LEN
    } mmef_bk_state_t;

    // index of the most significant non-zero 7-bit group
    function automatic logic [1:0] vlq_top_grp(input logic [ValueW-1:0] v);
        logic [1:0] g;
        if (v[27:21] != 7'd0)
        begin
            g = 2'd3;
        end
        else if (v[20:14] != 7'd0)
        begin
            g = 2'd2;
        end
        else if (v[13:7] != 7'd0)
        begin
            g = 2'd1;
        end
        else
        begin
            g = 2'd0;
        end
        return g;
    endfunction

    function automatic logic [7:0] vlq_byte(input logic [ValueW-1:0] v, input logic [1:0] g);
        logic [6:0] grp;
        unique case (g)
            2'd0: grp = v[6:0];
            2'd1: grp = v[13:7];
            2'd2: grp = v[20:14];
            2'd3: grp = v[27:21];
            default: grp = v[6:0];
        endcase
        return (g != 2'd0) ? (VLQ_CONT | {1'b0, grp}) : {1'b0, grp};
    endfunction

endpackage

`default_nettype wire

// ----- sv/mmef_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmef_queue #(
    parameter int Depth = mmef_pkg::QueueDepthDf
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mmef_pkg::mmef_qent_t push_ent,
    input  wire logic               pop,
    output mmef_pkg::mmef_qent_t    head,
    output mmef_pkg::mmef_qstat_t   stat
);
    import mmef_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    mmef_qent_t      mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CntFull);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mmef_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmef_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire mmef_pkg::mmef_in_t    cmd,
    input  wire mmef_pkg::mmef_qstat_t qstat,
    output logic                       push,
    output mmef_pkg::mmef_qent_t       push_ent
);
    import mmef_pkg::*;

    logic [ValueW-1:0] rem_reg, rem_next;
    logic              accept;

    assign cmd_stall = qstat.full;
    assign accept    = cmd_valid && !qstat.full;

    always_comb
    begin
        rem_next      = rem_reg;
        push          = 1'b0;
        push_ent.item = cmd;
        push_ent.last = (rem_reg == ValueW'(1));
        if (accept)
        begin
            unique case (cmd.command)
                CMD_HEADER:
                begin
                    push     = 1'b1;
                    rem_next = cmd.payload_length;
                end
                CMD_PAYLOAD:
                begin
                    // nothing pending: transaction dropped
                    if (rem_reg != '0)
                    begin
                        push     = 1'b1;
                        rem_next = rem_reg - 1'b1;
                    end
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mmef_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mmef_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mmef_pkg::mmef_qent_t  head,
    input  wire mmef_pkg::mmef_qstat_t qstat,
    output logic                       pop,
    output logic                       ser_valid,
    input  wire logic                  ser_stall,
    output mmef_pkg::mmef_out_t        ser
);
    import mmef_pkg::*;

    mmef_bk_state_t    state_reg, state_next;
    logic [1:0]        grp_reg, grp_next;
    logic [ValueW-1:0] delta_reg, delta_next;
    logic [ValueW-1:0] plen_reg, plen_next;
    logic [7:0]        type_reg, type_next;
    logic              out_valid_reg, out_valid_next;
    mmef_out_t         out_reg, out_next;
    logic              can_load;

    assign can_load  = !out_valid_reg || !ser_stall;
    assign ser_valid = out_valid_reg;
    assign ser       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        delta_next     = delta_reg;
        plen_next      = plen_reg;
        type_next      = type_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && ser_stall;
        pop            = 1'b0;
        if (can_load)
        begin
            unique case (state_reg)
                BK_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        pop = 1'b1;
                        if (head.item.command == CMD_PAYLOAD)
                        begin
                            out_valid_next     = 1'b1;
                            out_next.out_byte  = head.item.data_byte;
                            out_next.event_end = head.last;
                        end
                        else
                        begin
                            delta_next = head.item.delta_ticks;
                            plen_next  = head.item.payload_length;
                            type_next  = head.item.meta_type;
                            grp_next   = vlq_top_grp(head.item.delta_ticks);
                            state_next = BK_DELTA;
                        end
                    end
                end
                BK_DELTA:
                begin
                    out_valid_next     = 1'b1;
                    out_next.out_byte  = vlq_byte(delta_reg, grp_reg);
                    out_next.event_end = 1'b0;
                    if (grp_reg == 2'd0)
                    begin
                        state_next = BK_META;
                    end
                    else
                    begin
                        grp_next = grp_reg - 1'b1;
                    end
                end
                BK_META:
                begin
                    out_valid_next     = 1'b1;
                    out_next.out_byte  = META_BYTE;
                    out_next.event_end = 1'b0;
                    state_next         = BK_TYPE;
                end
                BK_TYPE:
                begin
                    out_valid_next     = 1'b1;
                    out_next.out_byte  = type_reg;
                    out_next.event_end = 1'b0;
                    grp_next           = vlq_top_grp(plen_reg);
                    state_next         = BK_LEN;
                end
                BK_LEN:
                begin
                    out_valid_next     = 1'b1;
                    out_next.out_byte  = vlq_byte(plen_reg, grp_reg);
                    out_next.event_end = (grp_reg == 2'd0) && (plen_reg == '0);
                    if (grp_reg == 2'd0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        grp_next = grp_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        delta_reg <= delta_next;
        plen_reg  <= plen_next;
        type_reg  <= type_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// ----- sv/midi_meta_event_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serialises a meta event: a header transaction (command 0) yields the delta time as a
// variable-length quantity, 0xFF, the type byte and the payload length as a variable-length
// quantity; payload transactions (command 1) then pass one byte each, event_end marking the
// final byte of the event. Payload with none pending is dropped; a new header abandons any
// unfinished payload. Payload bytes flow at one per cycle while the receiver does not stall. A
// header is first fetched from the queue into the serialiser, whose byte sequencer then emits
// its bytes one at a time; the front end keeps accepting into a QueueDepth-entry queue
// meanwhile, until the queue is full.
module midi_meta_event_framer #(
    parameter int QueueDepth = mmef_pkg::QueueDepthDf
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire mmef_pkg::mmef_in_t  cmd,
    output logic                     ser_valid,
    input  wire logic                ser_stall,
    output mmef_pkg::mmef_out_t      ser
);
    import mmef_pkg::*;

    logic        push, pop;
    mmef_qent_t  push_ent, head;
    mmef_qstat_t qstat;

    mmef_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .qstat    (qstat),
        .push     (push),
        .push_ent (push_ent)
    );

    mmef_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ent(push_ent),
        .pop     (pop),
        .head    (head),
        .stat    (qstat)
    );

    mmef_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .ser_valid(ser_valid),
        .ser_stall(ser_stall),
        .ser      (ser)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mmef_pkg::*;

    localparam int                IdleLimit  = 2000;
    localparam int                RandomGoal = 240;
    localparam int                CalmFrom   = 205;
    localparam int                TailCycles = 40;
    localparam logic [ValueW-1:0] ValueMax   = 28'h0fffffff;

    class meta_event_scoreboard;
        mmef_out_t         due_bytes[$];
        logic [ValueW-1:0] bytes_owed;
        int                errors;

        function new();
            bytes_owed = '0;
            errors     = 0;
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            mmef_out_t r;
            r.out_byte  = b;
            r.event_end = last;
            due_bytes.push_back(r);
        endfunction

        // 7-bit groups, most significant first, continuation bit on all but the last
        function void push_vlq(logic [ValueW-1:0] v);
            int top;
            top = 0;
            for (int g = 1; g < 4; g++)
            begin
                if (v[7*g +: 7] != 7'd0)
                begin
                    top = g;
                end
            end
            for (int g = top; g >= 0; g--)
            begin
                push_byte({(g != 0), v[7*g +: 7]}, 1'b0);
            end
        endfunction

        function void note_input(mmef_in_t it);
            mmef_out_t tail;
            if (it.command == CMD_HEADER)
            begin
                push_vlq(it.delta_ticks);
                push_byte(META_BYTE, 1'b0);
                push_byte(it.meta_type, 1'b0);
                push_vlq(it.payload_length);
                bytes_owed = it.payload_length;
                if (bytes_owed == '0)
                begin
                    tail           = due_bytes.pop_back();
                    tail.event_end = 1'b1;
                    due_bytes.push_back(tail);
                end
            end
            else if (bytes_owed != '0)
            begin
                bytes_owed = bytes_owed - 1'b1;
                push_byte(it.data_byte, bytes_owed == '0);
            end
        endfunction

        function void check_result(mmef_out_t got);
            mmef_out_t want;
            if (due_bytes.size() == 0)
            begin
                $error("unexpected byte: out_byte %h, event_end %b", got.out_byte, got.event_end);
                errors++;
                return;
            end
            want = due_bytes.pop_front();
            if (got.out_byte != want.out_byte)
            begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.event_end != want.event_end)
            begin
                $error("event_end: expected %b, got %b", want.event_end, got.event_end);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_bytes.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    mmef_in_t  cmd;
    logic      ser_valid;
    logic      ser_stall;
    mmef_out_t ser;

    meta_event_scoreboard sb;
    logic                 calm;
    int                   sender_quiet;
    int                   idle_cycles;

    midi_meta_event_framer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .ser_valid (ser_valid),
        .ser_stall (ser_stall),
        .ser       (ser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ser_valid && !ser_stall)
            begin
                sb.check_result(ser);
            end
            if (cmd_valid && !cmd_stall)
            begin
                sb.note_input(cmd);
            end
            if ((ser_valid && !ser_stall) || (cmd_valid && !cmd_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAIL midi_meta_event_framer");
                $finish;
            end
        end
    end

    // receiver back-pressure: stall bursts and quiet stretches
    initial
    begin
        int burst;
        int quiet;
        burst     = 0;
        quiet     = 0;
        ser_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
            end
            else if (quiet > 0)
            begin
                quiet--;
            end
            else if (!calm)
            begin
                case ($urandom_range(0, 9))
                    0, 1: burst = $urandom_range(1, 11);
                    2: quiet = $urandom_range(20, 60);
                    default: ;
                endcase
            end
            ser_stall <= (burst > 0);
        end
    end

    function automatic mmef_in_t header_item(logic [ValueW-1:0] delta, logic [7:0] mtype,
                                             logic [ValueW-1:0] plen);
        mmef_in_t it;
        it.command        = CMD_HEADER;
        it.delta_ticks    = delta;
        it.meta_type      = mtype;
        it.payload_length = plen;
        it.data_byte      = 8'($urandom());
        return it;
    endfunction

    function automatic mmef_in_t payload_item(logic [7:0] b);
        mmef_in_t it;
        it.command        = CMD_PAYLOAD;
        it.delta_ticks    = ValueW'($urandom());
        it.meta_type      = 8'($urandom());
        it.payload_length = ValueW'($urandom());
        it.data_byte      = b;
        return it;
    endfunction

    // random value spread over 1 to 4 groups
    function automatic logic [ValueW-1:0] vlq_value();
        int groups;
        groups = $urandom_range(1, 4);
        return ValueW'($urandom() & ((32'd1 << (7 * groups)) - 1));
    endfunction

    task automatic send_item(input mmef_in_t it);
        if (sender_quiet > 0)
        begin
            sender_quiet--;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            sender_quiet = $urandom_range(10, 30);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.outstanding() != 0);
    endtask

    initial
    begin
        int   event_items;
        int   kind;
        int   plen;
        int   cut;
        logic paused;
        sb           = new();
        calm         = 1'b0;
        sender_quiet = 0;
        idle_cycles  = 0;
        event_items  = 0;
        paused       = 1'b0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(payload_item(8'hff));                       // nothing pending: dropped
        send_item(header_item(28'd0, 8'h00, 28'd0));
        send_item(header_item(28'h7f, 8'hff, 28'd1));
        send_item(payload_item(8'h00));
        send_item(header_item(28'h80, 8'h51, 28'd3));
        send_item(payload_item(8'hff));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'ha5));
        send_item(payload_item(8'h5a));                       // after the end: dropped
        send_item(header_item(28'h3fff, 8'h03, 28'h7f));
        send_item(payload_item(8'h81));
        send_item(header_item(28'h4000, 8'h01, 28'h80));      // abandons the open event
        send_item(payload_item(8'h7e));
        send_item(header_item(28'h1fffff, 8'h58, 28'h3fff));
        send_item(header_item(28'h200000, 8'h59, 28'h4000));
        send_item(header_item(ValueMax, 8'h7f, ValueMax));    // ten-byte header
        send_item(payload_item(8'h3c));
        send_item(header_item(ValueMax, 8'h2f, 28'd0));
        send_item(header_item(28'h12, 8'h06, 28'd2));
        send_item(payload_item(8'h01));
        send_item(payload_item(8'hfe));
        drain();

        while (event_items < RandomGoal)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                send_item(header_item(vlq_value(), 8'($urandom()), ValueW'(plen)));
                event_items++;
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, plen) : plen;
                for (int i = 0; i < cut; i++)
                begin
                    send_item(payload_item(8'($urandom())));
                    event_items++;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(payload_item(8'($urandom())));
                end
            end
            else if (kind == 7)
            begin
                send_item(header_item(vlq_value(), 8'($urandom()), vlq_value()));
                event_items++;
                repeat ($urandom_range(0, 3))
                begin
                    send_item(payload_item(8'($urandom())));
                    event_items++;
                end
            end
            else if (kind == 8)
            begin
                send_item(payload_item(8'($urandom())));
            end
            else
            begin
                send_item(header_item(ValueW'($urandom()), 8'($urandom()), '0));
                event_items++;
            end
            if (event_items >= CalmFrom)
            begin
                calm = 1'b1;
            end
            if (!paused && event_items >= RandomGoal / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (TailCycles) @(negedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("PASS midi_meta_event_framer");
        end
        else
        begin
            $display("FAIL midi_meta_event_framer");
        end
        $finish;
    end

endmodule
